// ===== rtl/core/index_sort_with_statistics_top_macros.svh =====
// ----------------------------------------------------------------------------
// index_sort_with_statistics_top_macros.svh
// assertion macros shared by the index sort rtl
// ----------------------------------------------------------------------------
`ifndef INDEX_SORT_WITH_STATISTICS_TOP_MACROS_SVH
`define INDEX_SORT_WITH_STATISTICS_TOP_MACROS_SVH

// expression must hold at every edge outside reset
`define ISWS_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ISWS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/isws_pkg.sv =====
// ----------------------------------------------------------------------------
// isws_pkg
// port widths of the index sort with statistics block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isws_pkg;

   // fixed payload widths of the request and response beats
   localparam int VALUE_W  = 16;
   localparam int RANK_W   = 6;
   localparam int INDEX_W  = 6;
   localparam int MEDIAN_W = 17;
   localparam int SUM_W    = 22;
   localparam int COUNT_W  = 7;

endpackage

// ===== rtl/core/index_sort_with_statistics_top.sv =====
// ----------------------------------------------------------------------------
// index_sort_with_statistics_top
// loads a set of values, exchange-sorts an index permutation in memory and
// streams the sorted elements with median, sum and mode statistics
// ----------------------------------------------------------------------------
//
// channel | dir | handshake            | payload
// --------+-----+----------------------+-------------------------------------
// req     | in  | req_valid/req_stall  | value, last
// rsp     | out | rsp_valid/rsp_stall  | rank, orig_index, sorted_value, stats, final_res
//
// one request beat per cycle while loading; the beat with last closes the set
// single memory read port sets the pace: per outer position, a head read, a scan of the
// later entries and a write-back; statistics, then a read and a load per response beat
// reset is synchronous and clears only state, count, sum and response valid; memory is not cleared
// req_stall is high after the closing beat is taken until the final response is loaded
// the final response may wait under rsp_stall while the next set loads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "index_sort_with_statistics_top_macros.svh"

module index_sort_with_statistics_top #(
   parameter int MAX_COUNT  = 32,
   parameter int VALUE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [isws_pkg::VALUE_W-1:0]  req_value,
   input  logic                          req_last,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [isws_pkg::RANK_W-1:0]   rsp_rank,
   output logic [isws_pkg::INDEX_W-1:0]  rsp_orig_index,
   output logic [isws_pkg::VALUE_W-1:0]  rsp_sorted_value,
   output logic [isws_pkg::MEDIAN_W-1:0] rsp_median_twice,
   output logic [isws_pkg::SUM_W-1:0]    rsp_total_sum,
   output logic [isws_pkg::COUNT_W-1:0]  rsp_item_count,
   output logic [isws_pkg::COUNT_W-1:0]  rsp_max_frequency,
   output logic [isws_pkg::COUNT_W-1:0]  rsp_mode_count,
   output logic                          rsp_final_res
);

   import isws_pkg::*;

   // address, count and sum widths
   localparam int AW = $clog2(MAX_COUNT);
   localparam int CW = $clog2(MAX_COUNT + 1);
   localparam int SW = VALUE_BITS + CW;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_COUNT);

   // sequencer states
   localparam logic [3:0] ST_LOAD  = 4'd0;  // taking request beats
   localparam logic [3:0] ST_HEAD  = 4'd1;  // read entry at outer position
   localparam logic [3:0] ST_HEADW = 4'd2;  // latch it, read first later entry
   localparam logic [3:0] ST_SCAN  = 4'd3;  // compare and swap one later entry
   localparam logic [3:0] ST_TAIL  = 4'd4;  // write back outer position
   localparam logic [3:0] ST_STRD  = 4'd5;  // start statistics pass
   localparam logic [3:0] ST_STAT  = 4'd6;  // one sorted entry per cycle
   localparam logic [3:0] ST_EMRD  = 4'd7;  // read entry for next beat
   localparam logic [3:0] ST_EMWR  = 4'd8;  // load response register

   // one memory entry: original load position and its value
   typedef struct packed {
      logic [AW-1:0]         idx;
      logic [VALUE_BITS-1:0] val;
   } entry_type;

   // pair memory, one write and one registered read port
   entry_type mem_ff [MAX_COUNT];
   entry_type rd_data_ff;
   logic      mem_we;
   logic      mem_re;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   entry_type mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[mem_raddr];
      end
   end

   // control and working registers
   logic [3:0]            state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [SW-1:0]         sum_ff, sum_in;
   logic [AW-1:0]         p_ff, p_in;
   logic [AW-1:0]         r_ff, r_in;
   entry_type             cur_ff, cur_in;
   logic [VALUE_BITS-1:0] prev_val_ff, prev_val_in;
   logic [CW-1:0]         run_ff, run_in;
   logic [CW-1:0]         maxf_ff, maxf_in;
   logic [CW-1:0]         modes_ff, modes_in;
   logic [VALUE_BITS:0]   med_ff, med_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0]     rsp_rank_ff, rsp_rank_in;
   logic [INDEX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [VALUE_W-1:0]    rsp_val_ff, rsp_val_in;
   logic [MEDIAN_W-1:0]   rsp_med_ff, rsp_med_in;
   logic [SUM_W-1:0]      rsp_sum_ff, rsp_sum_in;
   logic [COUNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic [COUNT_W-1:0]    rsp_maxf_ff, rsp_maxf_in;
   logic [COUNT_W-1:0]    rsp_modes_ff, rsp_modes_in;
   logic                  rsp_final_ff, rsp_final_in;

   // width adaptation between fixed ports and parameterized datapath
   logic [VALUE_BITS+VALUE_W-1:0]  val_in_wide;
   logic [VALUE_BITS-1:0]          val_in;
   logic [VALUE_BITS+VALUE_W-1:0]  val_out_wide;
   logic [AW+RANK_W-1:0]           rank_out_wide;
   logic [AW+INDEX_W-1:0]          idx_out_wide;
   logic [VALUE_BITS+MEDIAN_W:0]   med_out_wide;
   logic [SW+SUM_W-1:0]            sum_out_wide;
   logic [CW+COUNT_W-1:0]          cnt_out_wide;
   logic [CW+COUNT_W-1:0]          maxf_out_wide;
   logic [CW+COUNT_W-1:0]          modes_out_wide;

   assign val_in_wide    = {{VALUE_BITS{1'b0}}, req_value};
   assign val_in         = val_in_wide[VALUE_BITS-1:0];
   assign val_out_wide   = {{VALUE_W{1'b0}}, rd_data_ff.val};
   assign rank_out_wide  = {{RANK_W{1'b0}}, r_ff};
   assign idx_out_wide   = {{INDEX_W{1'b0}}, rd_data_ff.idx};
   assign med_out_wide   = {{MEDIAN_W{1'b0}}, med_ff};
   assign sum_out_wide   = {{SUM_W{1'b0}}, sum_ff};
   assign cnt_out_wide   = {{COUNT_W{1'b0}}, cnt_ff};
   assign maxf_out_wide  = {{COUNT_W{1'b0}}, maxf_ff};
   assign modes_out_wide = {{COUNT_W{1'b0}}, modes_ff};

   logic          req_take;
   logic          rsp_take;
   logic          rsp_free;
   logic          keep_beat;
   logic [CW-1:0] n_next;
   logic [CW-1:0] run_next;
   logic          is_last_rank;

   assign req_stall = (state_ff != ST_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   // response register can take a new beat this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // values past a full store are dropped
   assign keep_beat = (cnt_ff < MAX_CNT);
   assign n_next    = keep_beat ? cnt_ff + CW'(1) : cnt_ff;
   // run length ending at the entry now on the read port
   assign run_next  = ((r_ff != '0) && (rd_data_ff.val == prev_val_ff)) ?
                      run_ff + CW'(1) : CW'(1);
   assign is_last_rank = ((CW'(r_ff) + CW'(1)) == cnt_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      p_in         = p_ff;
      r_in         = r_ff;
      cur_in       = cur_ff;
      prev_val_in  = prev_val_ff;
      run_in       = run_ff;
      maxf_in      = maxf_ff;
      modes_in     = modes_ff;
      med_in       = med_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = r_ff;
      mem_raddr    = r_ff;
      mem_wdata    = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_rank_in  = rsp_rank_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_med_in   = rsp_med_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_maxf_in  = rsp_maxf_ff;
      rsp_modes_in = rsp_modes_ff;
      rsp_final_in = rsp_final_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (keep_beat) begin
                  // identity permutation: entry k holds position k
                  mem_we    = 1'b1;
                  mem_waddr = cnt_ff[AW-1:0];
                  mem_wdata = '{idx: cnt_ff[AW-1:0], val: val_in};
                  sum_in    = sum_ff + SW'(val_in);
               end
               cnt_in = n_next;
               if (req_last) begin
                  p_in = '0;
                  if (n_next > CW'(1)) begin
                     state_in = ST_HEAD;
                  end else begin
                     state_in = ST_STRD;
                  end
               end
            end
         end

         ST_HEAD: begin
            mem_re    = 1'b1;
            mem_raddr = p_ff;
            state_in  = ST_HEADW;
         end

         ST_HEADW: begin
            // entry at p stays in cur until written back
            cur_in    = rd_data_ff;
            mem_re    = 1'b1;
            mem_raddr = p_ff + AW'(1);
            r_in      = p_ff + AW'(1);
            state_in  = ST_SCAN;
         end

         ST_SCAN: begin
            if (cur_ff.val > rd_data_ff.val) begin
               // swap: later slot takes cur, cur takes the smaller entry
               mem_we    = 1'b1;
               mem_waddr = r_ff;
               mem_wdata = cur_ff;
               cur_in    = rd_data_ff;
            end
            if ((CW'(r_ff) + CW'(1)) < cnt_ff) begin
               mem_re    = 1'b1;
               mem_raddr = r_ff + AW'(1);
               r_in      = r_ff + AW'(1);
            end else begin
               state_in = ST_TAIL;
            end
         end

         ST_TAIL: begin
            mem_we    = 1'b1;
            mem_waddr = p_ff;
            mem_wdata = cur_ff;
            p_in      = p_ff + AW'(1);
            if ((CW'(p_ff) + CW'(2)) < cnt_ff) begin
               state_in = ST_HEAD;
            end else begin
               state_in = ST_STRD;
            end
         end

         ST_STRD: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            r_in      = '0;
            run_in    = CW'(1);
            maxf_in   = CW'(1);
            modes_in  = '0;
            state_in  = ST_STAT;
         end

         ST_STAT: begin
            // single pass: count runs at the running maximum, restart on a new max
            run_in      = run_next;
            prev_val_in = rd_data_ff.val;
            if (run_next > maxf_ff) begin
               maxf_in  = run_next;
               modes_in = CW'(1);
            end else if (run_next == maxf_ff) begin
               modes_in = modes_ff + CW'(1);
            end
            if (CW'(r_ff) == (cnt_ff >> 1)) begin
               if (cnt_ff[0]) begin
                  med_in = {rd_data_ff.val, 1'b0};
               end else begin
                  med_in = {1'b0, rd_data_ff.val} + {1'b0, prev_val_ff};
               end
            end
            if (is_last_rank) begin
               r_in     = '0;
               state_in = ST_EMRD;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = r_ff + AW'(1);
               r_in      = r_ff + AW'(1);
            end
         end

         ST_EMRD: begin
            mem_re    = 1'b1;
            mem_raddr = r_ff;
            state_in  = ST_EMWR;
         end

         ST_EMWR: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_rank_in  = rank_out_wide[RANK_W-1:0];
               rsp_idx_in   = idx_out_wide[INDEX_W-1:0];
               rsp_val_in   = val_out_wide[VALUE_W-1:0];
               rsp_med_in   = med_out_wide[MEDIAN_W-1:0];
               rsp_sum_in   = sum_out_wide[SUM_W-1:0];
               rsp_cnt_in   = cnt_out_wide[COUNT_W-1:0];
               rsp_maxf_in  = maxf_out_wide[COUNT_W-1:0];
               rsp_modes_in = modes_out_wide[COUNT_W-1:0];
               rsp_final_in = is_last_rank;
               if (is_last_rank) begin
                  // set done, next request beat opens a new set
                  cnt_in   = '0;
                  sum_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  r_in     = r_ff + AW'(1);
                  state_in = ST_EMRD;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      r_ff         <= r_in;
      cur_ff       <= cur_in;
      prev_val_ff  <= prev_val_in;
      run_ff       <= run_in;
      maxf_ff      <= maxf_in;
      modes_ff     <= modes_in;
      med_ff       <= med_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_med_ff   <= rsp_med_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_maxf_ff  <= rsp_maxf_in;
      rsp_modes_ff <= rsp_modes_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rank          = rsp_rank_ff;
   assign rsp_orig_index    = rsp_idx_ff;
   assign rsp_sorted_value  = rsp_val_ff;
   assign rsp_median_twice  = rsp_med_ff;
   assign rsp_total_sum     = rsp_sum_ff;
   assign rsp_item_count    = rsp_cnt_ff;
   assign rsp_max_frequency = rsp_maxf_ff;
   assign rsp_mode_count    = rsp_modes_ff;
   assign rsp_final_res     = rsp_final_ff;

   // terms for the checks below
   logic stat_after_first;
   logic rsp_in_set;
   assign stat_after_first = (state_ff == ST_STAT) && (r_ff != '0);
   assign rsp_in_set = (COUNT_W'(rsp_rank_ff) < rsp_cnt_ff) && (rsp_maxf_ff <= rsp_cnt_ff);

   // load count never passes the store depth
   `ISWS_ASSERT_ALWAYS(a_cnt_bound, cnt_ff <= MAX_CNT, "load count above store depth")

   // inner scan always works on a position after the outer one
   `ISWS_ASSERT_IMPLY(a_scan_order, state_ff == ST_SCAN, r_ff > p_ff, "bad scan position")

   // the statistics pass sees a nondecreasing sequence
   `ISWS_ASSERT_IMPLY(a_sorted, stat_after_first, rd_data_ff.val >= prev_val_ff, "unsorted run")

   // every shown beat carries a rank inside the set and a sane max frequency
   `ISWS_ASSERT_IMPLY(a_rsp_rank, rsp_valid_ff, rsp_in_set, "response outside the set")

endmodule
